/* hdl/mwps_pkg.sv */
// ----------------------------------------------------------------------------
// mwps_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the minimum-weight parent selector.
// ----------------------------------------------------------------------------
package mwps_pkg;

   // neighbour table size and derived widths
   localparam int NEIGHBOR_SLOTS = 16;
   localparam int IDX_W          = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
   localparam int CNT_W          = $clog2(NEIGHBOR_SLOTS + 1);

   // field widths
   localparam int ADDR_W      = 16;
   localparam int WEIGHT_W    = 16;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_INDEX_W = 2;

   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [WEIGHT_W-1:0]    weight_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [COUNT_OUT_W-1:0] count_out_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // configuration register indexes
   localparam csr_index_type CSR_INTERFERENCE_COST = 2'd0;
   localparam csr_index_type CSR_IS_ROOT           = 2'd1;
   localparam csr_index_type CSR_INFINITE_WEIGHT   = 2'd2;

   localparam weight_type WEIGHT_MAX = '1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;   // latch the incoming beacon, start the walk
      logic step;   // examine one table entry
      logic merge;  // update or append the entry, fold an appended entry into the minimum
      logic weigh;  // settle parent and own weight
      logic emit;   // load the result register
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_done;  // every valid entry has been examined
      logic out_free;   // result register can take a new result
   } dp_status_type;

endpackage

/* hdl/mwps_ctrl.sv */
// ----------------------------------------------------------------------------
// mwps_ctrl
// Sequencer for one beacon: accept, walk the table, merge, weigh, emit.
// ----------------------------------------------------------------------------
module mwps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mwps_pkg::dp_status_type status,
   output mwps_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_WEIGH,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_MERGE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_WEIGH;
         end
         ST_WEIGH: begin
            cmd.weigh = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/mwps_datapath.sv */
// ----------------------------------------------------------------------------
// mwps_datapath
// Neighbour table, running minimum, node state, configuration registers and
// the result register.
// ----------------------------------------------------------------------------
module mwps_datapath (
   input  logic                          clock,
   input  logic                          reset,
   // commands and status
   input  mwps_pkg::dp_cmd_type          cmd,
   output mwps_pkg::dp_status_type       status,
   // beacon payload
   input  logic [15:0]                   req_sender_addr,
   input  logic [15:0]                   req_sender_weight,
   // configuration writes
   input  logic                          csr_valid,
   input  mwps_pkg::csr_index_type       csr_index,
   input  logic [15:0]                   csr_wdata,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_parent_addr,
   output logic                          rsp_parent_valid,
   output logic [15:0]                   rsp_node_weight,
   output logic                          rsp_beacon_enable,
   output logic                          rsp_dropped_full,
   output logic [4:0]                    rsp_neighbor_count
);

   // neighbour table, no reset: entries at or above the count are never read
   mwps_pkg::addr_type   addrs_ff   [mwps_pkg::NEIGHBOR_SLOTS];
   mwps_pkg::weight_type weights_ff [mwps_pkg::NEIGHBOR_SLOTS];
   mwps_pkg::cnt_type    count_ff;

   // configuration
   mwps_pkg::weight_type cost_ff;
   logic                 root_ff;
   mwps_pkg::weight_type inf_ff;

   // node state
   mwps_pkg::weight_type own_weight_ff;
   mwps_pkg::addr_type   parent_ff;
   logic                 have_parent_ff;

   // per-beacon working registers
   mwps_pkg::addr_type   beacon_addr_ff;
   mwps_pkg::weight_type beacon_weight_ff;
   mwps_pkg::cnt_type    scan_idx_ff;
   logic                 found_ff;
   mwps_pkg::idx_type    found_idx_ff;
   logic                 have_min_ff;
   mwps_pkg::weight_type min_weight_ff;
   mwps_pkg::addr_type   min_addr_ff;
   logic                 dropped_ff;

   // result register
   logic                 rsp_valid_ff;

   // current entry under the walk, with the beacon's weight substituted on a match
   mwps_pkg::idx_type    scan_idx;
   mwps_pkg::addr_type   entry_addr;
   mwps_pkg::weight_type entry_weight;
   logic                 entry_match;
   mwps_pkg::weight_type eff_weight;
   logic                 entry_better;
   logic                 table_has_room;
   logic                 append_better;
   logic [mwps_pkg::WEIGHT_W:0] weight_sum;

   assign scan_idx       = scan_idx_ff[mwps_pkg::IDX_W-1:0];
   assign entry_addr     = addrs_ff[scan_idx];
   assign entry_weight   = weights_ff[scan_idx];
   assign entry_match    = (entry_addr == beacon_addr_ff);
   assign eff_weight     = entry_match ? beacon_weight_ff : entry_weight;
   assign entry_better   = !have_min_ff || (eff_weight < min_weight_ff);
   assign table_has_room =
      (count_ff < mwps_pkg::cnt_type'(mwps_pkg::NEIGHBOR_SLOTS));
   assign append_better  = !have_min_ff || (beacon_weight_ff < min_weight_ff);
   assign weight_sum     = {1'b0, cost_ff} + {1'b0, min_weight_ff};

   assign status.scan_done = (scan_idx_ff == count_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= '0;
         root_ff <= 1'b0;
         inf_ff  <= mwps_pkg::WEIGHT_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            mwps_pkg::CSR_INTERFERENCE_COST: cost_ff <= csr_wdata;
            mwps_pkg::CSR_IS_ROOT:           root_ff <= csr_wdata[0];
            mwps_pkg::CSR_INFINITE_WEIGHT:   inf_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // table contents
   always_ff @(posedge clock) begin
      if (cmd.merge) begin
         if (found_ff) begin
            weights_ff[found_idx_ff] <= beacon_weight_ff;
         end else if (table_has_room) begin
            addrs_ff[count_ff[mwps_pkg::IDX_W-1:0]]   <= beacon_addr_ff;
            weights_ff[count_ff[mwps_pkg::IDX_W-1:0]] <= beacon_weight_ff;
         end
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.merge && !found_ff && table_has_room) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // walk over the table and running minimum
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         beacon_addr_ff   <= req_sender_addr;
         beacon_weight_ff <= req_sender_weight;
         scan_idx_ff      <= '0;
         found_ff         <= 1'b0;
         found_idx_ff     <= '0;
         have_min_ff      <= 1'b0;
         min_weight_ff    <= '0;
         min_addr_ff      <= '0;
         dropped_ff       <= 1'b0;
      end else if (cmd.step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (entry_match) begin
            found_ff     <= 1'b1;
            found_idx_ff <= scan_idx;
         end
         if (entry_better) begin
            have_min_ff   <= 1'b1;
            min_weight_ff <= eff_weight;
            min_addr_ff   <= entry_addr;
         end
      end else if (cmd.merge && !found_ff) begin
         // a new sender sits last in insertion order, so only a strictly lower weight wins
         if (table_has_room) begin
            if (append_better) begin
               have_min_ff   <= 1'b1;
               min_weight_ff <= beacon_weight_ff;
               min_addr_ff   <= beacon_addr_ff;
            end
         end else begin
            dropped_ff <= 1'b1;
         end
      end
   end

   // parent and own weight
   always_ff @(posedge clock) begin
      if (reset) begin
         own_weight_ff  <= mwps_pkg::WEIGHT_MAX;
         parent_ff      <= '0;
         have_parent_ff <= 1'b0;
      end else if (cmd.weigh) begin
         if (root_ff) begin
            own_weight_ff <= '0;
         end else if (have_min_ff) begin
            parent_ff      <= min_addr_ff;
            have_parent_ff <= 1'b1;
            own_weight_ff  <= weight_sum[mwps_pkg::WEIGHT_W] ? mwps_pkg::WEIGHT_MAX
                                                           : weight_sum[mwps_pkg::WEIGHT_W-1:0];
         end
      end
   end

   // result register, holds until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_parent_addr    <= parent_ff;
         rsp_parent_valid   <= have_parent_ff;
         rsp_node_weight    <= own_weight_ff;
         rsp_beacon_enable  <= (own_weight_ff < inf_ff);
         rsp_dropped_full   <= dropped_ff;
         rsp_neighbor_count <= mwps_pkg::count_out_type'(count_ff);
      end
   end

endmodule

/* hdl/min_weight_parent_selector_unit.sv */
// Each beacon is loaded, then the walk over the table runs at one entry per cycle, then the
// merge, weigh and emit steps follow; the next beacon is taken only after the emit step.
// A waiting result does not stop the next beacon from being taken; only the emit step waits.
// Reset (synchronous) empties the table, sets node weight to all ones, clears the parent
// and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// min_weight_parent_selector_unit
// Keeps a bounded neighbour table from received beacons and picks the
// neighbour of lowest weight as parent, reporting the resulting node weight.
// ----------------------------------------------------------------------------
module min_weight_parent_selector_unit (
   input  logic                    clock,
   input  logic                    reset,
   // beacon input
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [15:0]             req_sender_addr,
   input  logic [15:0]             req_sender_weight,
   // result output
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_parent_addr,
   output logic                    rsp_parent_valid,
   output logic [15:0]             rsp_node_weight,
   output logic                    rsp_beacon_enable,
   output logic                    rsp_dropped_full,
   output logic [4:0]              rsp_neighbor_count,
   // configuration writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata
);

   mwps_pkg::dp_cmd_type    cmd;
   mwps_pkg::dp_status_type status;

   // configuration is always taken
   assign csr_ready = 1'b1;

   // sequencer
   mwps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and arithmetic
   mwps_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sender_addr    (req_sender_addr),
      .req_sender_weight  (req_sender_weight),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parent_addr    (rsp_parent_addr),
      .rsp_parent_valid   (rsp_parent_valid),
      .rsp_node_weight    (rsp_node_weight),
      .rsp_beacon_enable  (rsp_beacon_enable),
      .rsp_dropped_full   (rsp_dropped_full),
      .rsp_neighbor_count (rsp_neighbor_count)
   );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the minimum-weight parent selector. Beacons are
// sent through a valid/ready channel while a built-in predictor keeps its own
// neighbour table and settings, and every result transfer is checked field
// by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;

   localparam mwps_pkg::csr_index_type CSR_SPARE   = 2'd3;
   localparam int                      STALL_LIMIT = 2000;
   localparam int                      PHASES      = 11;
   localparam int                      PHASE_ITEMS = 150;
   localparam int                      PRINT_LIMIT = 40;

   typedef struct {
      mwps_pkg::addr_type      parent_addr;
      logic                    parent_valid;
      mwps_pkg::weight_type    node_weight;
      logic                    beacon_enable;
      logic                    dropped_full;
      mwps_pkg::count_out_type neighbor_count;
   } selector_result_type;

   // clock, reset and block ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   mwps_pkg::addr_type      req_sender_addr = '0;
   mwps_pkg::weight_type    req_sender_weight = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   mwps_pkg::addr_type      rsp_parent_addr;
   logic                    rsp_parent_valid;
   mwps_pkg::weight_type    rsp_node_weight;
   logic                    rsp_beacon_enable;
   logic                    rsp_dropped_full;
   mwps_pkg::count_out_type rsp_neighbor_count;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   mwps_pkg::csr_index_type csr_index = '0;
   mwps_pkg::weight_type    csr_wdata = '0;

   // predictor state: neighbour table, own weight, parent and settings
   mwps_pkg::addr_type      tbl_addr [mwps_pkg::NEIGHBOR_SLOTS];
   mwps_pkg::weight_type    tbl_weight [mwps_pkg::NEIGHBOR_SLOTS];
   int                      tbl_used = 0;
   mwps_pkg::weight_type    cur_weight = mwps_pkg::WEIGHT_MAX;
   mwps_pkg::addr_type      cur_parent = '0;
   logic                    cur_parent_ok = 1'b0;
   mwps_pkg::weight_type    set_cost = '0;
   logic                    set_sink = 1'b0;
   mwps_pkg::weight_type    set_ceiling = mwps_pkg::WEIGHT_MAX;

   selector_result_type pending_results[$];

   int unsigned   req_idle_pct = 36;
   int unsigned   rsp_stall_pct = 36;
   int unsigned   mismatches = 0;
   int unsigned   results_checked = 0;
   int unsigned   beacons_sent = 0;
   int unsigned   beacons_dropped = 0;
   int unsigned   settings_applied = 0;
   int unsigned   quiet_cycles = 0;

   min_weight_parent_selector_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sender_addr    (req_sender_addr),
      .req_sender_weight  (req_sender_weight),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parent_addr    (rsp_parent_addr),
      .rsp_parent_valid   (rsp_parent_valid),
      .rsp_node_weight    (rsp_node_weight),
      .rsp_beacon_enable  (rsp_beacon_enable),
      .rsp_dropped_full   (rsp_dropped_full),
      .rsp_neighbor_count (rsp_neighbor_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 4-unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // table update and parent choice for one beacon
   function automatic selector_result_type predict_beacon(mwps_pkg::addr_type addr,
                                                          mwps_pkg::weight_type weight);
      selector_result_type         r;
      logic                        hit;
      mwps_pkg::weight_type        best_w;
      mwps_pkg::addr_type          best_a;
      logic [mwps_pkg::WEIGHT_W:0] total;
      hit = 1'b0;
      r.dropped_full = 1'b0;
      for (int k = 0; k < tbl_used; k++) begin
         if (!hit && tbl_addr[k] == addr) begin
            tbl_weight[k] = weight;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (tbl_used < mwps_pkg::NEIGHBOR_SLOTS) begin
            tbl_addr[tbl_used] = addr;
            tbl_weight[tbl_used] = weight;
            tbl_used++;
         end else begin
            r.dropped_full = 1'b1;
         end
      end
      // a sink never looks for a parent and advertises zero
      if (set_sink) begin
         cur_weight = '0;
      end else if (tbl_used != 0) begin
         best_w = tbl_weight[0];
         best_a = tbl_addr[0];
         for (int k = 1; k < tbl_used; k++) begin
            if (tbl_weight[k] < best_w) begin
               best_w = tbl_weight[k];
               best_a = tbl_addr[k];
            end
         end
         cur_parent = best_a;
         cur_parent_ok = 1'b1;
         total = {1'b0, set_cost} + {1'b0, best_w};
         cur_weight = total[mwps_pkg::WEIGHT_W] ? mwps_pkg::WEIGHT_MAX
                                                : total[mwps_pkg::WEIGHT_W-1:0];
      end
      r.parent_addr = cur_parent;
      r.parent_valid = cur_parent_ok;
      r.node_weight = cur_weight;
      r.beacon_enable = (cur_weight < set_ceiling);
      r.neighbor_count = mwps_pkg::count_out_type'(tbl_used);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h",
                                   results_checked, name, got, want));
   endtask

   // one beacon transfer, with random idle cycles ahead of it
   task automatic send_beacon(mwps_pkg::addr_type addr, mwps_pkg::weight_type weight);
      selector_result_type r;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sender_addr <= addr;
      req_sender_weight <= weight;
      do @(posedge clock); while (!req_ready);
      r = predict_beacon(addr, weight);
      pending_results.push_back(r);
      beacons_sent++;
      if (r.dropped_full)
         beacons_dropped++;
   endtask

   // stop sending and wait until every predicted result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic csr_put(mwps_pkg::csr_index_type index, mwps_pkg::weight_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         mwps_pkg::CSR_INTERFERENCE_COST: set_cost = data;
         mwps_pkg::CSR_IS_ROOT:           set_sink = data[0];
         mwps_pkg::CSR_INFINITE_WEIGHT:   set_ceiling = data;
         default: ;
      endcase
   endtask

   // all three registers; the sink flag carries junk in its upper bits
   task automatic write_settings(mwps_pkg::weight_type cost, logic sink,
                                 mwps_pkg::weight_type ceiling);
      csr_put(mwps_pkg::CSR_INTERFERENCE_COST, cost);
      csr_put(mwps_pkg::CSR_IS_ROOT,
              mwps_pkg::weight_type'({15'($urandom_range(0, 16'h7FFF)), sink}));
      csr_put(mwps_pkg::CSR_INFINITE_WEIGHT, ceiling);
      csr_valid <= 1'b0;
      settings_applied++;
      @(posedge clock);
   endtask

   // first beacon straight out of reset, register defaults untouched
   task automatic test_reset_defaults();
      send_beacon(16'h0000, mwps_pkg::WEIGHT_MAX);
      wait_for_results();
   endtask

   // minimum search with ties kept by the earlier entry
   task automatic test_min_selection();
      write_settings(16'h0100, 1'b0, 16'h8000);
      send_beacon(16'hFFFF, 16'h0000);
      send_beacon(16'h1234, 16'h0000);
      send_beacon(16'hFFFF, 16'h0500);
      send_beacon(16'h1234, 16'h0500);
      send_beacon(16'h8001, 16'h7F00);
      send_beacon(16'h8001, 16'h0001);
      wait_for_results();
   endtask

   // cost plus parent weight clipped at the top, and a zero threshold
   task automatic test_weight_saturation();
      write_settings(mwps_pkg::WEIGHT_MAX, 1'b0, 16'h0000);
      send_beacon(16'h0001, 16'h00FF);
      send_beacon(16'h0001, 16'h0000);
      wait_for_results();
   endtask

   // sink node: weight forced to zero, parent held, then back to normal
   task automatic test_sink_node();
      write_settings(16'h0200, 1'b1, 16'h0000);
      send_beacon(16'h00AA, 16'h0010);
      wait_for_results();
      write_settings(16'h0200, 1'b1, 16'h0001);
      send_beacon(16'h00AA, 16'h0020);
      wait_for_results();
      write_settings(16'h0200, 1'b0, mwps_pkg::WEIGHT_MAX);
      send_beacon(16'h00AA, 16'h0030);
      wait_for_results();
   endtask

   // a write to the unused register index changes nothing
   task automatic test_spare_register();
      csr_put(CSR_SPARE, mwps_pkg::weight_type'($urandom));
      csr_valid <= 1'b0;
      send_beacon(16'h5555, 16'hAAAA);
      wait_for_results();
   endtask

   // fill every slot, then a new sender is dropped and a known one updated
   task automatic test_table_full();
      int fill;
      fill = mwps_pkg::NEIGHBOR_SLOTS - tbl_used;
      for (int k = 0; k < fill; k++)
         send_beacon({4'hC, 4'(k), 8'h3C}, mwps_pkg::weight_type'($urandom));
      send_beacon(16'h7E7E, 16'h0040);
      send_beacon(16'h1234, 16'h0000);
      wait_for_results();
   endtask

   // random beacons over a full table, settings changed between phases
   task automatic test_random_traffic();
      mwps_pkg::addr_type   addr;
      mwps_pkg::weight_type weight;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_settings(16'h0000, 1'b0, mwps_pkg::WEIGHT_MAX);
            1: write_settings(mwps_pkg::WEIGHT_MAX, 1'b0, 16'h0000);
            2: write_settings(16'h0000, 1'b1, 16'h0000);
            3: write_settings(mwps_pkg::WEIGHT_MAX, 1'b1, mwps_pkg::WEIGHT_MAX);
            default: write_settings($urandom_range(0, 1)
                                       ? mwps_pkg::weight_type'($urandom_range(0, 16'h0C00))
                                       : mwps_pkg::weight_type'($urandom),
                                    ($urandom_range(0, 3) == 0),
                                    mwps_pkg::weight_type'($urandom));
         endcase
         // one phase runs flat out on both sides
         if (phase == 5) begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mostly updates to known neighbours, the rest unknown senders
            if ($urandom_range(0, 99) < 80)
               addr = tbl_addr[$urandom_range(0, tbl_used - 1)];
            else
               addr = mwps_pkg::addr_type'($urandom);
            case ($urandom_range(0, 9))
               0:       weight = '0;
               1:       weight = mwps_pkg::WEIGHT_MAX;
               2, 3, 4: weight = mwps_pkg::weight_type'($urandom_range(1, 3) << 8);
               default: weight = mwps_pkg::weight_type'($urandom);
            endcase
            send_beacon(addr, weight);
         end
         wait_for_results();
         req_idle_pct = 36;
         rsp_stall_pct = 36;
      end
   endtask

   // result side back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      selector_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing pending, parent %h",
                                      rsp_parent_addr));
         end else begin
            want = pending_results.pop_front();
            compare_field("parent_addr", rsp_parent_addr, want.parent_addr);
            compare_field("parent_valid", 16'(rsp_parent_valid), 16'(want.parent_valid));
            compare_field("node_weight", rsp_node_weight, want.node_weight);
            compare_field("beacon_enable", 16'(rsp_beacon_enable),
                          16'(want.beacon_enable));
            compare_field("dropped_full", 16'(rsp_dropped_full), 16'(want.dropped_full));
            compare_field("neighbor_count", 16'(rsp_neighbor_count),
                          16'(want.neighbor_count));
            results_checked++;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  quiet_cycles, pending_results.size());
         $display("** min_weight_parent_selector_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_min_selection();
      test_weight_saturation();
      test_sink_node();
      test_spare_register();
      test_table_full();
      test_random_traffic();
      wait_for_results();
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      $display("run covered %0d beacons (%0d dropped on a full table) over %0d settings",
               beacons_sent, beacons_dropped, settings_applied);
      $display("%0d results checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0)
         $display("** min_weight_parent_selector_unit: PASSED **");
      else
         $display("** min_weight_parent_selector_unit: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
hdl/mwps_pkg.sv
hdl/mwps_ctrl.sv
hdl/mwps_datapath.sv
hdl/min_weight_parent_selector_unit.sv
tb/testbench.sv
